/* design/interval_room_allocator_macros.svh */
// assertion helpers used by the allocator controller
`ifndef INTERVAL_ROOM_ALLOCATOR_MACROS_SVH
`define INTERVAL_ROOM_ALLOCATOR_MACROS_SVH

// property checked at every rising clock edge outside reset
`define IRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("interval_room_allocator: check failed");

// condition in one cycle implies a condition in the next
`define IRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval_room_allocator: sequence check failed");

`endif

/* design/iram_pkg.sv */
package iram_pkg;

  // fixed field widths and the default room count
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned OUT_W     = 11;
  localparam int unsigned ROOMS_DEF = 1024;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_DOWN,
    ST_UP,
    ST_PLACE,
    ST_DONE
  } state_t;

  // one finished result
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [OUT_W-1:0] room;
    logic [OUT_W-1:0] in_use;
    logic             full;
  } res_t;

endpackage

/* design/iram_mem.sv */
module iram_mem import iram_pkg::*; #(
  parameter int unsigned DEPTH = ROOMS_DEF,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 43
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  // heap entries: departure over room number
  logic [DW-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* design/iram_ctrl.sv */
`include "interval_room_allocator_macros.svh"

module iram_ctrl import iram_pkg::*; #(
  parameter int unsigned ROOMS = ROOMS_DEF,
  parameter int unsigned AW    = 10,
  parameter int unsigned CW    = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  // request side
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TIME_W-1:0]   in_arrival_time,
  input  logic [TIME_W-1:0]   in_departure_time,
  input  logic [TAG_W-1:0]    in_request_tag,
  // result side
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  // heap memory
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [TIME_W+CW-1:0] mem_wdata,
  output logic [AW-1:0]       mem_raddr_a,
  output logic [AW-1:0]       mem_raddr_b,
  input  logic [TIME_W+CW-1:0] mem_rdata_a,
  input  logic [TIME_W+CW-1:0] mem_rdata_b
);

  // child indexes reach twice the heap size
  localparam int unsigned IW = CW + 1;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] arr_r, arr_nxt;
  logic [TIME_W-1:0] dep_r, dep_nxt;
  logic [CW-1:0]     elem_room_r, elem_room_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     lchild_r, lchild_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     room_r, room_nxt;
  logic              full_r, full_nxt;

  logic [TIME_W-1:0] dep_a, dep_b, best_dep;
  logic [CW-1:0]     room_a, room_b, best_room;
  logic [IW-1:0]     rchild, best_idx, next_l, next_r, count_ext;
  logic              take_r, best_lt_elem, elem_lt_par;
  logic [AW-1:0]     par_idx, gpar_idx;

  // read data split into key fields
  assign dep_a  = mem_rdata_a[TIME_W+CW-1 -: TIME_W];
  assign room_a = mem_rdata_a[CW-1:0];
  assign dep_b  = mem_rdata_b[TIME_W+CW-1 -: TIME_W];
  assign room_b = mem_rdata_b[CW-1:0];

  // sift-down child selection
  assign count_ext = IW'(count_r);
  assign rchild    = lchild_r + IW'(1);
  assign take_r    = (rchild < count_ext) &&
                     ((dep_b < dep_a) || ((dep_b == dep_a) && (room_b < room_a)));
  assign best_dep  = take_r ? dep_b : dep_a;
  assign best_room = take_r ? room_b : room_a;
  assign best_idx  = take_r ? rchild : lchild_r;
  assign best_lt_elem = (best_dep < dep_r) ||
                        ((best_dep == dep_r) && (best_room < elem_room_r));
  assign next_l    = (best_idx << 1) + IW'(1);
  assign next_r    = next_l + IW'(1);

  // sift-up parent compare
  assign par_idx     = (idx_r - AW'(1)) >> 1;
  assign gpar_idx    = (par_idx - AW'(1)) >> 1;
  assign elem_lt_par = (dep_r < dep_a) || ((dep_r == dep_a) && (elem_room_r < room_a));

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arr_r       <= arr_nxt;
    dep_r       <= dep_nxt;
    elem_room_r <= elem_room_nxt;
    tag_r       <= tag_nxt;
    idx_r       <= idx_nxt;
    lchild_r    <= lchild_nxt;
    room_r      <= room_nxt;
    full_r      <= full_nxt;
  end

  // next state, memory requests
  always_comb begin
    state_nxt     = state_r;
    arr_nxt       = arr_r;
    dep_nxt       = dep_r;
    elem_room_nxt = elem_room_r;
    tag_nxt       = tag_r;
    idx_nxt       = idx_r;
    lchild_nxt    = lchild_r;
    count_nxt     = count_r;
    room_nxt      = room_r;
    full_nxt      = full_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = {dep_r, elem_room_r};
    mem_raddr_a   = '0;
    mem_raddr_b   = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          arr_nxt = in_arrival_time;
          dep_nxt = in_departure_time;
          tag_nxt = in_request_tag;
          // root read goes out now
          mem_raddr_a = '0;
          if (count_r != '0) begin
            state_nxt = ST_ROOT;
          end else begin
            // empty heap: first room at the root
            elem_room_nxt = CW'(1);
            room_nxt      = CW'(1);
            full_nxt      = 1'b0;
            idx_nxt       = '0;
            count_nxt     = CW'(1);
            state_nxt     = ST_PLACE;
          end
        end
      end
      ST_ROOT: begin
        if (dep_a < arr_r) begin
          // reuse the earliest freed room, then sift down
          room_nxt      = room_a;
          elem_room_nxt = room_a;
          full_nxt      = 1'b0;
          idx_nxt       = '0;
          lchild_nxt    = IW'(1);
          if (count_ext > IW'(1)) begin
            mem_raddr_a = AW'(1);
            mem_raddr_b = AW'(2);
            state_nxt   = ST_DOWN;
          end else begin
            state_nxt = ST_PLACE;
          end
        end else if (count_r < CW'(ROOMS)) begin
          // open a new room at the end, then sift up
          room_nxt      = count_r + CW'(1);
          elem_room_nxt = count_r + CW'(1);
          full_nxt      = 1'b0;
          idx_nxt       = count_r[AW-1:0];
          count_nxt     = count_r + CW'(1);
          mem_raddr_a   = (count_r[AW-1:0] - AW'(1)) >> 1;
          state_nxt     = ST_UP;
        end else begin
          // all rooms taken, heap untouched
          room_nxt  = '0;
          full_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DOWN: begin
        if (best_lt_elem) begin
          // smaller child moves up into the hole
          mem_we     = 1'b1;
          mem_wdata  = {best_dep, best_room};
          idx_nxt    = best_idx[AW-1:0];
          lchild_nxt = next_l;
          if (next_l < count_ext) begin
            mem_raddr_a = next_l[AW-1:0];
            mem_raddr_b = next_r[AW-1:0];
          end else begin
            state_nxt = ST_PLACE;
          end
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_UP: begin
        if (elem_lt_par) begin
          // parent moves down into the hole
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_a;
          idx_nxt   = par_idx;
          if (par_idx != '0) begin
            mem_raddr_a = gpar_idx;
          end else begin
            state_nxt = ST_PLACE;
          end
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        // moving entry lands in the hole
        mem_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields, masked to the port widths
  assign res.tag    = tag_r;
  assign res.room   = OUT_W'(room_r);
  assign res.in_use = OUT_W'(count_r);
  assign res.full   = full_r;

  `IRA_ASSERT(a_count_range, count_r <= CW'(ROOMS))
  `IRA_ASSERT(a_full_needs_full_heap, (res_valid && full_r) |-> (count_r == CW'(ROOMS)))
  `IRA_ASSERT(a_room_zero_iff_full, res_valid |-> ((room_r == '0) == full_r))
  `IRA_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready,
                   state_r == ST_ROOT || state_r == ST_PLACE)

endmodule

/* design/interval_room_allocator.sv */
// channel  direction  ports                                         handshake
// in       input      in_arrival_time, in_departure_time,           in_valid / in_ready
//                     in_request_tag
// out      output     out_result_tag, out_assigned_room,            out_valid / out_ready
//                     out_rooms_in_use, out_rooms_full
//
// one item at a time: accept, root read, heap walk level by level, placement write,
// result hand-off; an empty heap skips the read and walk, a full hotel the walk and write
// the walk is bounded by the single heap memory (two read ports, one write port)
// rst_n is synchronous; it empties the heap, memory contents need no clearing
// a result waits in the output register while the next item is taken; the
// controller stalls only when a newer result is ready and that register is still full
module interval_room_allocator import iram_pkg::*; #(
  parameter int unsigned ROOMS = ROOMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TIME_W-1:0] in_arrival_time,
  input  logic [TIME_W-1:0] in_departure_time,
  input  logic [TAG_W-1:0]  in_request_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TAG_W-1:0]  out_result_tag,
  output logic [OUT_W-1:0]  out_assigned_room,
  output logic [OUT_W-1:0]  out_rooms_in_use,
  output logic              out_rooms_full
);

  localparam int unsigned AW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int unsigned CW = $clog2(ROOMS + 1);
  localparam int unsigned DW = TIME_W + CW;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [DW-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_r;
  res_t          out_res_r;

  // heap storage
  iram_mem #(
    .DEPTH (ROOMS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // heap walk sequencer
  iram_ctrl #(
    .ROOMS (ROOMS),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_arrival_time   (in_arrival_time),
    .in_departure_time (in_departure_time),
    .in_request_tag    (in_request_tag),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr_a       (mem_raddr_a),
    .mem_raddr_b       (mem_raddr_b),
    .mem_rdata_a       (mem_rdata_a),
    .mem_rdata_b       (mem_rdata_b)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_tag    = out_res_r.tag;
  assign out_assigned_room = out_res_r.room;
  assign out_rooms_in_use  = out_res_r.in_use;
  assign out_rooms_full    = out_res_r.full;

endmodule

/* dv/interval_room_allocator_tb.sv */
`timescale 1ns / 100ps

module interval_room_allocator_tb import iram_pkg::*;;

  localparam int unsigned ROOMS        = ROOMS_DEF;
  localparam int          RESET_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [TIME_W-1:0] in_arrival_time;
  logic [TIME_W-1:0] in_departure_time;
  logic [TAG_W-1:0]  in_request_tag;
  logic              out_valid;
  logic              out_ready;
  logic [TAG_W-1:0]  out_result_tag;
  logic [OUT_W-1:0]  out_assigned_room;
  logic [OUT_W-1:0]  out_rooms_in_use;
  logic              out_rooms_full;

  interval_room_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_arrival_time   (in_arrival_time),
    .in_departure_time (in_departure_time),
    .in_request_tag    (in_request_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_tag    (out_result_tag),
    .out_assigned_room (out_assigned_room),
    .out_rooms_in_use  (out_rooms_in_use),
    .out_rooms_full    (out_rooms_full)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predicted occupancy heap, keyed by (departure, room)
  logic [TIME_W-1:0] occ_dep  [ROOMS];
  logic [OUT_W-1:0]  occ_room [ROOMS];
  int unsigned       occ_count;

  res_t pending_results[$];

  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_reused;
  int          n_refused;
  int          source_calm;
  int          sink_calm;
  bit          hold_req;
  logic [31:0] day_cursor;
  logic [31:0] last_dep;

  // heap ordering: departure first, then room number
  function automatic bit occ_less(input int unsigned x, input int unsigned y);
    if (occ_dep[x] != occ_dep[y]) return occ_dep[x] < occ_dep[y];
    return occ_room[x] < occ_room[y];
  endfunction

  function automatic void occ_swap(input int unsigned x, input int unsigned y);
    logic [TIME_W-1:0] d;
    logic [OUT_W-1:0]  r;
    d = occ_dep[x];
    r = occ_room[x];
    occ_dep[x] = occ_dep[y];
    occ_room[x] = occ_room[y];
    occ_dep[y] = d;
    occ_room[y] = r;
  endfunction

  // reuse the earliest freed room or open a new one, queue the expected result
  function automatic void allocate_room(input logic [TIME_W-1:0] arr,
                                        input logic [TIME_W-1:0] dep,
                                        input logic [TAG_W-1:0] tag);
    res_t        r;
    int unsigned i;
    int unsigned p;
    int unsigned l;
    int unsigned best;
    r.tag  = tag;
    r.room = '0;
    r.full = 1'b0;
    if (occ_count > 0 && occ_dep[0] < arr) begin
      r.room = occ_room[0];
      occ_dep[0] = dep;
      n_reused++;
      // sift down from the root
      i = 0;
      while (2 * i + 1 < occ_count) begin
        l = 2 * i + 1;
        best = l;
        if (l + 1 < occ_count && occ_less(l + 1, l)) best = l + 1;
        if (!occ_less(best, i)) break;
        occ_swap(best, i);
        i = best;
      end
    end else if (occ_count < ROOMS) begin
      r.room = OUT_W'(occ_count + 1);
      occ_dep[occ_count] = dep;
      occ_room[occ_count] = OUT_W'(occ_count + 1);
      occ_count++;
      // sift up from the new leaf
      i = occ_count - 1;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!occ_less(i, p)) break;
        occ_swap(i, p);
        i = p;
      end
    end else begin
      r.full = 1'b1;
      n_refused++;
    end
    r.in_use = OUT_W'(occ_count);
    pending_results = {pending_results, r};
  endfunction

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one booking item and wait for it to be taken
  task automatic send_booking(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] dep,
                              input logic [TAG_W-1:0] tag, input bit eager);
    int gap;
    gap = eager ? 0 : idle_len(source_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_arrival_time   <= arr;
    in_departure_time <= dep;
    in_request_tag    <= tag;
    allocate_room(arr, dep, tag);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // one booking that keeps the stream sorted by arrival then departure
  task automatic send_sorted(input int unsigned span, input bit eager);
    logic [31:0] dep;
    int          step;
    step = $urandom_range(0, 3);
    day_cursor = day_cursor + step;
    dep = day_cursor + $urandom_range(0, span);
    if (step == 0 && dep < last_dep) dep = last_dep;
    last_dep = dep;
    send_booking(day_cursor, dep, TAG_W'($urandom), eager);
  endtask

  task automatic send_noise();
    send_booking($urandom, $urandom, TAG_W'($urandom), 1'b0);
  endtask

  // field extremes, tie on departure, equal arrival and departure, reversed times
  task automatic test_directed_bookings();
    send_booking(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0);
    send_booking(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0);
    send_booking(32'h0000_0001, 32'h0000_0005, 16'h0001, 1'b1);
    send_booking(32'h0000_0005, 32'h0000_0005, 16'h0002, 1'b1);
    send_booking(32'h0000_0005, 32'h0000_000A, 16'h0003, 1'b0);
    send_booking(32'h0000_0006, 32'h0000_0002, 16'h0004, 1'b0);
    send_booking(32'h0000_0000, 32'hFFFF_FFFF, 16'h5555, 1'b1);
    send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA, 1'b1);
    send_booking(32'hFFFF_FFFF, 32'h0000_0000, 16'h8000, 1'b0);
    send_booking(32'hAAAA_AAAA, 32'h5555_5555, 16'h7FFF, 1'b0);
    send_booking(32'h5555_5555, 32'hAAAA_AAAA, 16'h00FF, 1'b1);
    send_booking(32'h8000_0000, 32'h7FFF_FFFF, 16'hFF00, 1'b0);
    send_booking(32'h7FFF_FFFF, 32'h8000_0000, 16'h1234, 1'b0);
    send_booking(32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'hFFFE, 1'b1);
  endtask

  // sorted booking runs with random content and some unsorted noise
  task automatic test_sorted_bookings(input int count);
    int          k;
    int          run;
    int unsigned span;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
        k++;
      end else begin
        run = $urandom_range(3, 16);
        span = $urandom_range(0, 48);
        repeat (run) begin
          send_sorted(span, 1'b0);
          k++;
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (40) send_sorted(24, 1'b1);
  endtask

  // open every room, then ask for more than the hotel holds
  task automatic test_rooms_exhausted();
    while (occ_count < ROOMS) send_booking(32'h0, $urandom, TAG_W'($urandom), 1'b0);
    repeat (20) send_booking(32'h0, $urandom, TAG_W'($urandom), 1'b0);
    // arrival equal to the earliest departure must not reuse
    repeat (5) send_booking(occ_dep[0], $urandom, TAG_W'($urandom), 1'b0);
    send_booking(32'h0, 32'h0, 16'hFFFF, 1'b0);
  endtask

  // deep reuse on a full heap, mixed with refused and unsorted items
  task automatic test_full_hotel_bookings(input int count);
    int          k;
    int          run;
    int          r;
    int unsigned span;
    k = 0;
    while (k < count) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_booking(32'h0, $urandom, TAG_W'($urandom), 1'b0);
        k++;
      end else if (r < 25) begin
        send_noise();
        k++;
      end else begin
        // jump ahead past the earliest departure so rooms come free
        if ($urandom_range(0, 2) == 0 && day_cursor <= occ_dep[0])
          day_cursor = occ_dep[0] + 1;
        run = $urandom_range(3, 16);
        span = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 1 << 24);
        repeat (run) begin
          send_sorted(span, 1'b0);
          k++;
        end
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_reused    = 0;
    n_refused   = 0;
    occ_count   = 0;
    source_calm = 0;
    sink_calm   = 0;
    hold_req    = 1'b0;
    day_cursor  = 32'd1000;
    last_dep    = 32'd1000;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_arrival_time   <= '0;
    in_departure_time <= '0;
    in_request_tag    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_bookings();
    test_sorted_bookings(420);
    test_output_stall();
    test_rooms_exhausted();
    test_full_hotel_bookings(450);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("interval_room_allocator_tb: %0d bookings sent, %0d results checked, %0d reused",
             n_sent, n_checked, n_reused);
    $display("interval_room_allocator_tb: peak %0d rooms open, %0d refused with all taken",
             occ_count, n_refused);
    if (n_errors == 0) begin
      $display("interval_room_allocator_tb: done, clean");
    end else begin
      $display("interval_room_allocator_tb: done, errors");
    end
    $finish;
  end

  // result receiver with random stalls and one long hold-off
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_len(sink_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [TAG_W-1:0] want,
                                      input logic [TAG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no booking waiting, expected none, actual tag %0h",
                 $time, out_result_tag);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("result_tag", want.tag, out_result_tag);
        check_field("assigned_room", TAG_W'(want.room), TAG_W'(out_assigned_room));
        check_field("rooms_in_use", TAG_W'(want.in_use), TAG_W'(out_rooms_in_use));
        check_field("rooms_full", TAG_W'(want.full), TAG_W'(out_rooms_full));
      end
    end
  end

  // overall time limit
  initial begin : watchdog
    #3000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("interval_room_allocator_tb: done, errors");
    $finish;
  end

endmodule

/* interval_room_allocator.f */
+incdir+design
design/iram_pkg.sv
design/iram_mem.sv
design/iram_ctrl.sv
design/interval_room_allocator.sv
dv/interval_room_allocator_tb.sv
